// File: rtl/core/g2n_pkg.sv
// Shared types, constants and latency figures of the geodetic to NED converter.
`default_nettype none
package g2n_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int MUL_LAT      = 4;
  localparam int DIV_STAGES   = 31;
  localparam int NEWTON_STEPS = 5;

  // angle prep, pi product, divide, sign, rotations, quadrant fix
  localparam int SC_LAT     = DIV_STAGES + CORDIC_STEPS + 5;
  localparam int NEWTON_LAT = 3 * MUL_LAT + 1;
  localparam int T_W        = SC_LAT + 2 * MUL_LAT + 1;
  localparam int T_N        = T_W + NEWTON_STEPS * NEWTON_LAT;
  localparam int ECEF_LAT   = T_N + 3 * MUL_LAT + 1;
  localparam int PIPE_LAT   = ECEF_LAT + 2 * MUL_LAT + 4;

  typedef logic signed [63:0] q_t;
  typedef logic [5:0] sh_t;

  localparam q_t ONE_Q60       = 64'sh1000_0000_0000_0000;
  localparam q_t THREE_Q60     = 64'sh3000_0000_0000_0000;
  localparam q_t PI_Q60        = 64'sh3243_F6A8_885A_308D;
  localparam q_t KINV_Q60      = 64'sd700114967507367826;
  localparam q_t E2_Q60        = 64'sd7718094650643534;
  localparam q_t ONE_M_E2      = ONE_Q60 - E2_Q60;
  localparam q_t SEMI_MAJOR_MM = 64'sd6378137000;
  localparam logic [30:0] DIV_D = 31'd1800000000;

  localparam sh_t SH_Q60 = 6'd60;
  localparam sh_t SH_Q61 = 6'd61;
  localparam sh_t SH_MM  = 6'd44;

  typedef enum logic [1:0] {
    CFG_REF_LAT = 2'd0,
    CFG_REF_LON = 2'd1,
    CFG_REF_ALT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    q_t sp;
    q_t cp;
    q_t sl;
    q_t cl;
  } trig_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } ecef_t;

  // non-negative quotient by shift and subtract, used for elaboration-time tables
  function automatic q_t quot_q(input q_t num, input q_t den);
    q_t quo;
    q_t rem;
    quo = '0;
    rem = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], num[bi]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q60 from the alternating series
  function automatic q_t atan_q60(input int i);
    q_t acc;
    int e;
    acc = '0;
    if (i == 0) begin
      return PI_Q60 >>> 2;
    end
    for (int k = 0; k < 64; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        if (k[0]) begin
          acc = acc - quot_q(q_t'(1) <<< e, q_t'(2 * k + 1));
        end else begin
          acc = acc + quot_q(q_t'(1) <<< e, q_t'(2 * k + 1));
        end
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/g2n_mul.sv
// Pipelined signed 64x64 multiply, shift right and truncate toward zero.
`default_nettype none
module g2n_mul (
  input  logic          clk,
  input  g2n_pkg::q_t   a,
  input  g2n_pkg::q_t   b,
  input  g2n_pkg::sh_t  sh,
  output g2n_pkg::q_t   p
);
  import g2n_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r;
  logic         ng1_r, ng2_r, ng3_r;
  logic [62:0]  mag;
  q_t           p_r;

  assign mag = prod_r[62 + sh -: 63];

  always_ff @(posedge clk) begin
    ua_r   <= a[63] ? 64'(-a) : 64'(a);
    ub_r   <= b[63] ? 64'(-b) : 64'(b);
    ng1_r  <= a[63] ^ b[63];
    p00_r  <= ua_r[31:0]  * ub_r[31:0];
    p01_r  <= ua_r[31:0]  * ub_r[63:32];
    p10_r  <= ua_r[63:32] * ub_r[31:0];
    p11_r  <= ua_r[63:32] * ub_r[63:32];
    ng2_r  <= ng1_r;
    prod_r <= {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
              + {p11_r, 64'b0};
    ng3_r  <= ng2_r;
    p_r    <= ng3_r ? -q_t'({1'b0, mag}) : q_t'({1'b0, mag});
  end

  assign p = p_r;

endmodule
`default_nettype wire

// File: rtl/core/g2n_sincos.sv
// Pipelined sine/cosine of an angle in 1e-7 degree, Q60 result.
`default_nettype none
module g2n_sincos (
  input  logic               clk,
  input  logic signed [31:0] ang,
  output g2n_pkg::q_t        sin_o,
  output g2n_pkg::q_t        cos_o
);
  import g2n_pkg::*;

  localparam logic signed [33:0] D90  = 34'sd900000000;
  localparam logic signed [33:0] D180 = 34'sd1800000000;
  localparam logic signed [33:0] D360 = 34'sd3600000000;
  localparam logic [61:0]        PI62 = PI_Q60[61:0];

  logic signed [33:0] wr, fd;
  logic               fl_nxt;
  logic [29:0]        mag_nxt, mag_r;
  logic [1:0]         fl_r [SC_LAT-1];   // {quadrant flip, negative}
  logic [60:0]        ppl_r, pph_r;
  logic [30:0]        rem_s [DIV_STAGES+1];
  logic [61:0]        rst_s [DIV_STAGES+1];
  logic [61:0]        quo_s [DIV_STAGES+1];
  q_t                 cx [CORDIC_STEPS+1];
  q_t                 cy [CORDIC_STEPS+1];
  q_t                 cz [CORDIC_STEPS+1];
  q_t                 sin_r, cos_r;

  // wrap to [-180,180), fold to [-90,90]
  always_comb begin
    wr = 34'(ang);
    if (wr >= D180) begin
      wr = wr - D360;
    end else if (wr < -D180) begin
      wr = wr + D360;
    end
    fd     = wr;
    fl_nxt = 1'b0;
    if (wr > D90) begin
      fd     = D180 - wr;
      fl_nxt = 1'b1;
    end else if (wr < -D90) begin
      fd     = -D180 - wr;
      fl_nxt = 1'b1;
    end
    mag_nxt = fd[33] ? 30'(-fd) : 30'(fd);
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    fl_r[0]  <= {fl_nxt, fd[33]};
    for (int j = 1; j < SC_LAT - 1; j++) begin
      fl_r[j] <= fl_r[j-1];
    end
    ppl_r    <= 61'(mag_r) * 61'(PI62[30:0]);
    pph_r    <= 61'(mag_r) * 61'(PI62[61:31]);
    {rem_s[0], rst_s[0]} <= 93'(ppl_r) + (93'(pph_r) << 31);
    quo_s[0] <= '0;
  end

  // restoring divide by 180 degrees, two quotient bits a stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [31:0] c1, c2;
    logic [30:0] r1, r2;
    logic        b1, b2;
    always_comb begin
      c1 = {rem_s[j], rst_s[j][61]};
      b1 = c1 >= {1'b0, DIV_D};
      r1 = b1 ? 31'(c1 - {1'b0, DIV_D}) : c1[30:0];
      c2 = {r1, rst_s[j][60]};
      b2 = c2 >= {1'b0, DIV_D};
      r2 = b2 ? 31'(c2 - {1'b0, DIV_D}) : c2[30:0];
    end
    always_ff @(posedge clk) begin
      rem_s[j+1] <= r2;
      rst_s[j+1] <= {rst_s[j][59:0], 2'b00};
      quo_s[j+1] <= {quo_s[j][59:0], b1, b2};
    end
  end

  always_ff @(posedge clk) begin
    cx[0] <= KINV_Q60;
    cy[0] <= '0;
    cz[0] <= fl_r[2+DIV_STAGES][0] ? -q_t'({2'b0, quo_s[DIV_STAGES]})
                                   : q_t'({2'b0, quo_s[DIV_STAGES]});
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam q_t ANG = atan_q60(i);
    always_ff @(posedge clk) begin
      if (!cz[i][63]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ANG;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= cy[CORDIC_STEPS];
    cos_r <= fl_r[SC_LAT-2][1] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// File: rtl/core/g2n_ecef.sv
// Pipelined WGS-84 geodetic to ECEF conversion (Q16 mm), with the trig terms.
`default_nettype none
module g2n_ecef (
  input  logic               clk,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [27:0] alt,
  output g2n_pkg::ecef_t     pos,
  output g2n_pkg::trig_t     trig
);
  import g2n_pkg::*;

  localparam int TRG_LEN = ECEF_LAT - SC_LAT;
  localparam int ALT_LEN = T_N + 2 * MUL_LAT;
  localparam int W_LEN   = (NEWTON_STEPS - 1) * NEWTON_LAT + MUL_LAT;

  q_t                 s_lat, c_lat, s_lon, c_lon;
  trig_t              tr0;
  trig_t              trg_d [TRG_LEN];
  logic signed [27:0] alt_d [ALT_LEN];
  q_t                 ss, e2ss, w_r;
  q_t                 w_d [W_LEN];
  q_t                 r_s [NEWTON_STEPS+1];
  q_t                 n, nn, rc, h1, h2, s_r, q2_r, px, py, pz;

  g2n_sincos u_sc_lat (.clk(clk), .ang(32'(lat)), .sin_o(s_lat), .cos_o(c_lat));
  g2n_sincos u_sc_lon (.clk(clk), .ang(lon),      .sin_o(s_lon), .cos_o(c_lon));

  assign tr0 = '{sp: s_lat, cp: c_lat, sl: s_lon, cl: c_lon};

  always_ff @(posedge clk) begin
    trg_d[0] <= tr0;
    for (int j = 1; j < TRG_LEN; j++) begin
      trg_d[j] <= trg_d[j-1];
    end
    alt_d[0] <= alt;
    for (int j = 1; j < ALT_LEN; j++) begin
      alt_d[j] <= alt_d[j-1];
    end
  end

  // w = 1 - e2 * sin^2(lat)
  g2n_mul u_ss (.clk(clk), .a(s_lat),  .b(s_lat), .sh(SH_Q60), .p(ss));
  g2n_mul u_e2 (.clk(clk), .a(E2_Q60), .b(ss),    .sh(SH_Q60), .p(e2ss));

  always_ff @(posedge clk) begin
    w_r    <= ONE_Q60 - e2ss;
    w_d[0] <= w_r;
    for (int j = 1; j < W_LEN; j++) begin
      w_d[j] <= w_d[j-1];
    end
  end

  // Newton steps for 1/sqrt(w)
  assign r_s[0] = ONE_Q60;

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_nt
    q_t rr, u, v_r;
    q_t r_d [2*MUL_LAT+1];
    g2n_mul u_rr (.clk(clk), .a(r_s[k]), .b(r_s[k]), .sh(SH_Q60), .p(rr));
    g2n_mul u_u  (.clk(clk), .a(w_d[k*NEWTON_LAT+MUL_LAT-1]), .b(rr), .sh(SH_Q60),
                  .p(u));
    always_ff @(posedge clk) begin
      v_r    <= THREE_Q60 - u;
      r_d[0] <= r_s[k];
      for (int j = 1; j < 2 * MUL_LAT + 1; j++) begin
        r_d[j] <= r_d[j-1];
      end
    end
    g2n_mul u_r (.clk(clk), .a(r_d[2*MUL_LAT]), .b(v_r), .sh(SH_Q61), .p(r_s[k+1]));
  end

  // prime vertical radius, then the three axes
  g2n_mul u_n  (.clk(clk), .a(SEMI_MAJOR_MM), .b(r_s[NEWTON_STEPS]), .sh(SH_MM), .p(n));
  g2n_mul u_nn (.clk(clk), .a(n), .b(ONE_M_E2), .sh(SH_Q60), .p(nn));

  assign h1 = q_t'(alt_d[T_N+MUL_LAT-1]) <<< 16;
  assign h2 = q_t'(alt_d[T_N+2*MUL_LAT-1]) <<< 16;

  always_ff @(posedge clk) begin
    s_r  <= n + h1;
    q2_r <= nn + h2;
  end

  g2n_mul u_rc (.clk(clk), .a(s_r), .b(trg_d[T_N+MUL_LAT-SC_LAT].cp), .sh(SH_Q60),
                .p(rc));
  g2n_mul u_x  (.clk(clk), .a(rc), .b(trg_d[T_N+2*MUL_LAT-SC_LAT].cl), .sh(SH_Q60),
                .p(px));
  g2n_mul u_y  (.clk(clk), .a(rc), .b(trg_d[T_N+2*MUL_LAT-SC_LAT].sl), .sh(SH_Q60),
                .p(py));
  g2n_mul u_z  (.clk(clk), .a(q2_r), .b(trg_d[T_N+2*MUL_LAT-SC_LAT].sp), .sh(SH_Q60),
                .p(pz));

  assign pos  = '{x: px, y: py, z: pz};
  assign trig = trg_d[TRG_LEN-1];

endmodule
`default_nettype wire

// File: rtl/core/geodetic_to_ned_converter.sv
// Top level: WGS-84 geodetic position to NED offset from a configured reference.
// Pipeline: a request reaches out_valid through the chain of 64-bit multipliers in the
//   Newton and rotation stages plus the CORDIC and divide pipes.
// Throughput: one request per cycle; busy is never raised and out_valid cannot be held.
// Reset: rst_n low clears the valid pipe and the reference registers to zero.
`default_nettype none
module geodetic_to_ned_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [27:0] in_altitude,
  output logic               out_valid,
  output logic signed [34:0] out_north,
  output logic signed [34:0] out_east,
  output logic signed [34:0] out_down,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import g2n_pkg::*;

  localparam q_t OUT_MAX = 64'sd17179869183;
  localparam q_t OUT_MIN = -64'sd17179869184;

  typedef struct packed {
    q_t cd2;
    q_t sd2;
    q_t cd1;
    q_t sd0;
  } prd_t;

  // round half up to mm, then clamp to the 35-bit output range
  function automatic logic signed [34:0] finish(input q_t v);
    q_t t;
    t = (v + 64'sd32768) >>> 16;
    if (t > OUT_MAX) begin
      t = OUT_MAX;
    end else if (t < OUT_MIN) begin
      t = OUT_MIN;
    end
    return t[34:0];
  endfunction

  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  logic signed [27:0] ref_alt_r;
  logic signed [30:0] lat0_r, rlat0_r;
  logic signed [31:0] lon0_r, rlon0_r;
  logic signed [27:0] alt0_r, ralt0_r;
  logic               vld_r [PIPE_LAT+1];
  ecef_t              cur_pos, ref_pos, d_r;
  trig_t              ref_trig, rt_r;
  trig_t              rt_d [MUL_LAT+1];
  q_t                 m_cd0, m_sd1, m_cd2, m_sd2, m_cd1, m_sd0, m_sp, m_cp;
  prd_t               prd_c;
  prd_t               md [MUL_LAT+1];
  q_t                 p_r, sn_r, se_r, sd_r;
  logic signed [34:0] north_r, east_r, down_r;

  // The pipe never stalls: a request is taken every cycle that start is high.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Reference registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      ref_alt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REF_LAT: ref_lat_r <= cfg_data[30:0];
        CFG_REF_LON: ref_lon_r <= cfg_data;
        CFG_REF_ALT: ref_alt_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // Valid bits ride alongside the data; the datapath itself runs every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PIPE_LAT + 1; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int j = 1; j < PIPE_LAT + 1; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  // Capture the request and the reference together so the reference path
  // sees exactly the register values that were live when the request came in.
  always_ff @(posedge clk) begin
    lat0_r  <= in_latitude;
    lon0_r  <= in_longitude;
    alt0_r  <= in_altitude;
    rlat0_r <= ref_lat_r;
    rlon0_r <= ref_lon_r;
    ralt0_r <= ref_alt_r;
  end

  // Two identical ECEF pipes: the position and the reference origin.
  g2n_ecef u_cur (.clk(clk), .lat(lat0_r), .lon(lon0_r), .alt(alt0_r),
                  .pos(cur_pos), .trig());
  g2n_ecef u_ref (.clk(clk), .lat(rlat0_r), .lon(rlon0_r), .alt(ralt0_r),
                  .pos(ref_pos), .trig(ref_trig));

  // ECEF difference and reference trig terms
  always_ff @(posedge clk) begin
    d_r.x <= cur_pos.x - ref_pos.x;
    d_r.y <= cur_pos.y - ref_pos.y;
    d_r.z <= cur_pos.z - ref_pos.z;
    rt_r  <= ref_trig;
  end

  // First rotation rank: the products cl*dx, sl*dy, cp*dz, sp*dz, cl*dy and sl*dx.
  g2n_mul u_m0 (.clk(clk), .a(rt_r.cl), .b(d_r.x), .sh(SH_Q60), .p(m_cd0));
  g2n_mul u_m1 (.clk(clk), .a(rt_r.sl), .b(d_r.y), .sh(SH_Q60), .p(m_sd1));
  g2n_mul u_m2 (.clk(clk), .a(rt_r.cp), .b(d_r.z), .sh(SH_Q60), .p(m_cd2));
  g2n_mul u_m3 (.clk(clk), .a(rt_r.sp), .b(d_r.z), .sh(SH_Q60), .p(m_sd2));
  g2n_mul u_m4 (.clk(clk), .a(rt_r.cl), .b(d_r.y), .sh(SH_Q60), .p(m_cd1));
  g2n_mul u_m5 (.clk(clk), .a(rt_r.sl), .b(d_r.x), .sh(SH_Q60), .p(m_sd0));

  assign prd_c = '{cd2: m_cd2, sd2: m_sd2, cd1: m_cd1, sd0: m_sd0};

  // p = cl*dx + sl*dy; trig and first-rank products wait for the second rank
  always_ff @(posedge clk) begin
    p_r     <= m_cd0 + m_sd1;
    rt_d[0] <= rt_r;
    md[0]   <= prd_c;
    for (int j = 1; j < MUL_LAT + 1; j++) begin
      rt_d[j] <= rt_d[j-1];
      md[j]   <= md[j-1];
    end
  end

  // Second rotation rank
  g2n_mul u_m6 (.clk(clk), .a(rt_d[MUL_LAT].sp), .b(p_r), .sh(SH_Q60), .p(m_sp));
  g2n_mul u_m7 (.clk(clk), .a(rt_d[MUL_LAT].cp), .b(p_r), .sh(SH_Q60), .p(m_cp));

  // north = cp*dz - sp*p, east = cl*dy - sl*dx, down = -cp*p - sp*dz
  always_ff @(posedge clk) begin
    sn_r    <= md[MUL_LAT].cd2 - m_sp;
    se_r    <= md[MUL_LAT].cd1 - md[MUL_LAT].sd0;
    sd_r    <= -m_cp - md[MUL_LAT].sd2;
    north_r <= finish(sn_r);
    east_r  <= finish(se_r);
    down_r  <= finish(sd_r);
  end

  assign out_valid = vld_r[PIPE_LAT];
  assign out_north = north_r;
  assign out_east  = east_r;
  assign out_down  = down_r;

  // A result strobe traces back to exactly one request, a fixed latency earlier.
  a_out_has_request : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT + 1))
    else $error("result strobe without a matching request");

  // A position equal to the reference gives a zero offset on every axis.
  a_zero_offset : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_latitude == ref_lat_r &&
                        in_longitude == ref_lon_r && in_altitude == ref_alt_r,
                        PIPE_LAT + 1))
    |-> (out_north == 35'sd0 && out_east == 35'sd0 && out_down == 35'sd0))
    else $error("nonzero offset for a position at the reference");

endmodule
`default_nettype wire
